/* hw/rtl/lpp_pkg.sv */
// Shared constants, types and helpers for the line point projector.
`default_nettype none

package lpp_pkg;

    // Coordinate format: signed Q16.16
    localparam int CW    = 32;
    localparam int FB    = 16;
    // Normalised direction magnitudes lie in [2^29, 2^30)
    localparam int SQW   = 30;
    // Unit component magnitude never exceeds 2^16 + 1
    localparam int UW    = 18;
    // Shift-add accumulator and square-root working width
    localparam int ACCW  = 64;
    // Dividend for the unit component: (mag << FB) + n/2
    localparam int DIVW  = SQW + FB + 1;
    // Root of the sum of squares fits in this many bits
    localparam int NW    = 32;
    localparam int CNTW  = 6;
    localparam int AXW   = 2;
    localparam int NAX   = 3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BASE_X = 3'd0,
        CFG_BASE_Y = 3'd1,
        CFG_BASE_Z = 3'd2,
        CFG_END_X  = 3'd3,
        CFG_END_Y  = 3'd4,
        CFG_END_Z  = 3'd5
    } t_cfg_idx;

    // Sequencer states, one-hot
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NORM  = 13'b0000000000010,
        S_SQ    = 13'b0000000000100,
        S_SQRT  = 13'b0000000001000,
        S_DIVLD = 13'b0000000010000,
        S_DIV   = 13'b0000000100000,
        S_DOTLD = 13'b0000001000000,
        S_DOT   = 13'b0000010000000,
        S_TSAT  = 13'b0000100000000,
        S_PRJLD = 13'b0001000000000,
        S_PRJ   = 13'b0010000000000,
        S_PADD  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    // Clamp a wide signed value to the coordinate range
    function automatic logic [CW-1:0] sat_cw(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] hi;
        logic signed [ACCW-1:0] lo;
        hi = ACCW'(signed'({1'b0, {(CW-1){1'b1}}}));
        lo = -hi - ACCW'(1);
        if (v > hi)
            return {1'b0, {(CW-1){1'b1}}};
        else if (v < lo)
            return {1'b1, {(CW-1){1'b0}}};
        else
            return v[CW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/line_point_projector_core.sv */
// Top level of the line point projector: sequencer with bit-serial arithmetic.
`default_nettype none

// Channel   | Dir | Payload (lowest bit first)
// s stream  | in  | tdata: point_x, point_y, point_z; tuser: first_of_set
// m stream  | out | tdata: proj_x, proj_y, proj_z, line_param, extent_min,
//           |     |        extent_max, zero pad; tuser: degenerate
// cfg write | in  | index 0..5 base_x..end_z, 32-bit data
//
// With the direction already built an item runs three shift-add products for
// t and three for the projection, one bit of the unit component per cycle
// through the shared accumulator.
// After a register write the first item also rebuilds the direction: up to
// 29 normalise shifts, 3 x 30 square steps, 32 root steps, 3 x 47 divide steps.
// Reset is synchronous; the output register lets the next item enter while a
// result waits to be taken.
module line_point_projector_core
    import lpp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // stream in
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [3*CW-1:0]   i_s_tdata,   // point_x, point_y, point_z
    input  wire logic              i_s_tuser,   // first_of_set
    // stream out
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [6*CW-1:0]        o_m_tdata,   // proj_x, proj_y, proj_z, line_param,
                                                // extent_min, extent_max, pad
    output logic                   o_m_tuser,   // degenerate
    // configuration
    input  wire logic              i_cfg_wr_en,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [CW-1:0]     i_cfg_wdata
);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_base [NAX];
    logic [CW-1:0]       r_end  [NAX];
    logic [CW:0]         r_mag  [NAX], n_mag [NAX];
    logic                r_neg  [NAX], n_neg [NAX];
    logic [UW-1:0]       r_umag [NAX], n_umag [NAX];
    logic                r_uneg [NAX], n_uneg [NAX];
    logic [CW-1:0]       r_pt   [NAX], n_pt  [NAX];
    logic [CW-1:0]       r_proj [NAX], n_proj [NAX];
    logic                r_first, n_first;
    logic                r_dir_ready, n_dir_ready;
    logic                r_degen, n_degen;
    logic [ACCW-1:0]     r_acc, n_acc;
    logic [ACCW-1:0]     r_mcand, n_mcand;
    logic [SQW-1:0]      r_mplr, n_mplr;
    logic [ACCW-1:0]     r_bit, n_bit;
    logic [NW-1:0]       r_n, n_n;
    logic [NW-1:0]       r_rem, n_rem;
    logic [DIVW-1:0]     r_quo, n_quo;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [AXW-1:0]      r_ax, n_ax;
    logic [CW-1:0]       r_t, n_t;
    logic [CW-1:0]       r_run_min, n_run_min;
    logic [CW-1:0]       r_run_max, n_run_max;
    logic                r_out_valid, n_out_valid;
    logic [CW-1:0]       r_o_proj [NAX], n_o_proj [NAX];
    logic [CW-1:0]       r_o_t, n_o_t;
    logic [CW-1:0]       r_o_min, n_o_min;
    logic [CW-2:0]       r_o_max, n_o_max;
    logic                r_o_degen, n_o_degen;

    logic signed [CW:0]  w_d [NAX];
    logic                w_mag_big, w_mag_small, w_mag_zero;
    logic [ACCW-1:0]     w_mul_sum;
    logic                w_mul_last;
    logic [ACCW-1:0]     w_rb;
    logic [NW:0]         w_trial;
    logic                w_ge;
    logic [ACCW-1:0]     w_diff;
    logic [ACCW-1:0]     w_tx;
    logic signed [ACCW-1:0] w_padd;
    logic signed [CW-1:0] w_bmin, w_bmax;
    logic [CW-1:0]       w_nmin, w_nmax;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NAX; i++) begin
                r_base[i] <= '0;
                r_end[i]  <= (i == 0) ? (CW'(1) << FB) : '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_BASE_X: r_base[0] <= i_cfg_wdata;
                CFG_BASE_Y: r_base[1] <= i_cfg_wdata;
                CFG_BASE_Z: r_base[2] <= i_cfg_wdata;
                CFG_END_X:  r_end[0]  <= i_cfg_wdata;
                CFG_END_Y:  r_end[1]  <= i_cfg_wdata;
                CFG_END_Z:  r_end[2]  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Line difference per axis and normalisation tests
    always_comb begin
        w_mag_big   = 1'b0;
        w_mag_small = 1'b1;
        w_mag_zero  = 1'b1;
        for (int i = 0; i < NAX; i++) begin
            w_d[i] = $signed({r_end[i][CW-1], r_end[i]}) -
                     $signed({r_base[i][CW-1], r_base[i]});
            if (r_mag[i][CW:SQW] != '0)
                w_mag_big = 1'b1;
            if (r_mag[i][CW:SQW-1] != '0)
                w_mag_small = 1'b0;
            if (r_mag[i] != '0)
                w_mag_zero = 1'b0;
        end
    end

    // Shared arithmetic terms
    assign w_mul_sum  = r_acc + (r_mplr[0] ? r_mcand : '0);
    assign w_mul_last = (r_cnt == CNTW'(1));
    assign w_rb       = r_mcand + r_bit;
    assign w_trial    = {r_rem, r_quo[DIVW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_n});
    assign w_diff     = ACCW'($signed({r_pt[r_ax][CW-1], r_pt[r_ax]}) -
                              $signed({r_base[r_ax][CW-1], r_base[r_ax]}));
    assign w_tx       = ACCW'($signed(r_t));
    assign w_padd     = ACCW'($signed(r_base[r_ax])) + ($signed(r_acc) >>> FB);
    assign w_bmin     = r_first ? '0 : $signed(r_run_min);
    assign w_bmax     = r_first ? '0 : $signed(r_run_max);
    assign w_nmin     = ($signed(r_t) < w_bmin) ? r_t : w_bmin;
    assign w_nmax     = ($signed(r_t) > w_bmax) ? r_t : w_bmax;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_umag      = r_umag;
        n_uneg      = r_uneg;
        n_pt        = r_pt;
        n_proj      = r_proj;
        n_first     = r_first;
        n_dir_ready = r_dir_ready;
        n_degen     = r_degen;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplr      = r_mplr;
        n_bit       = r_bit;
        n_n         = r_n;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_ax        = r_ax;
        n_t         = r_t;
        n_run_min   = r_run_min;
        n_run_max   = r_run_max;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_o_proj    = r_o_proj;
        n_o_t       = r_o_t;
        n_o_min     = r_o_min;
        n_o_max     = r_o_max;
        n_o_degen   = r_o_degen;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_pt[0] = i_s_tdata[CW-1:0];
                    n_pt[1] = i_s_tdata[2*CW-1:CW];
                    n_pt[2] = i_s_tdata[3*CW-1:2*CW];
                    n_first = i_s_tuser;
                    n_ax    = '0;
                    if (r_dir_ready) begin
                        n_state = S_DOTLD;
                    end else begin
                        for (int i = 0; i < NAX; i++) begin
                            n_neg[i] = w_d[i][CW];
                            n_mag[i] = w_d[i][CW] ? (CW+1)'(-w_d[i]) : w_d[i];
                        end
                        n_state = S_NORM;
                    end
                end
            end
            // scale all magnitudes until the largest is in [2^29, 2^30)
            S_NORM: begin
                if (w_mag_zero) begin
                    for (int i = 0; i < NAX; i++) begin
                        n_umag[i] = '0;
                        n_uneg[i] = 1'b0;
                    end
                    n_degen     = 1'b1;
                    n_dir_ready = 1'b1;
                    n_state     = S_DOTLD;
                end else if (w_mag_big) begin
                    for (int i = 0; i < NAX; i++)
                        n_mag[i] = r_mag[i] >> 1;
                end else if (w_mag_small) begin
                    for (int i = 0; i < NAX; i++)
                        n_mag[i] = r_mag[i] << 1;
                end else begin
                    n_acc   = '0;
                    n_mcand = ACCW'(r_mag[0][SQW-1:0]);
                    n_mplr  = r_mag[0][SQW-1:0];
                    n_cnt   = CNTW'(SQW);
                    n_ax    = '0;
                    n_state = S_SQ;
                end
            end
            // sum of squares, one multiplier bit a cycle
            S_SQ: begin
                n_acc   = w_mul_sum;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt - CNTW'(1);
                if (w_mul_last) begin
                    if (r_ax == AXW'(NAX-1)) begin
                        n_mcand = '0;
                        n_bit   = ACCW'(1) << (ACCW-2);
                        n_state = S_SQRT;
                    end else begin
                        n_ax    = r_ax + AXW'(1);
                        n_mcand = ACCW'(r_mag[r_ax + AXW'(1)][SQW-1:0]);
                        n_mplr  = r_mag[r_ax + AXW'(1)][SQW-1:0];
                        n_cnt   = CNTW'(SQW);
                    end
                end
            end
            // integer square root, two radicand bits a cycle
            S_SQRT: begin
                if (r_acc >= w_rb) begin
                    n_acc   = r_acc - w_rb;
                    n_mcand = (r_mcand >> 1) + r_bit;
                end else begin
                    n_mcand = r_mcand >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_n     = n_mcand[NW-1:0];
                    n_ax    = '0;
                    n_state = S_DIVLD;
                end
            end
            S_DIVLD: begin
                n_quo   = (DIVW'(r_mag[r_ax][SQW-1:0]) << FB) + DIVW'(r_n >> 1);
                n_rem   = '0;
                n_cnt   = CNTW'(DIVW);
                n_state = S_DIV;
            end
            // restoring division, one quotient bit a cycle
            S_DIV: begin
                n_rem = w_ge ? NW'(w_trial - {1'b0, r_n}) : w_trial[NW-1:0];
                n_quo = {r_quo[DIVW-2:0], w_ge};
                n_cnt = r_cnt - CNTW'(1);
                if (w_mul_last) begin
                    n_umag[r_ax] = n_quo[UW-1:0];
                    n_uneg[r_ax] = r_neg[r_ax];
                    if (r_ax == AXW'(NAX-1)) begin
                        n_degen     = 1'b0;
                        n_dir_ready = 1'b1;
                        n_ax        = '0;
                        n_state     = S_DOTLD;
                    end else begin
                        n_ax    = r_ax + AXW'(1);
                        n_state = S_DIVLD;
                    end
                end
            end
            // t accumulates u_i * (p_i - base_i) with the rounding half preloaded
            S_DOTLD: begin
                if (r_ax == '0)
                    n_acc = ACCW'(1) << (FB-1);
                n_mcand = r_uneg[r_ax] ? -w_diff : w_diff;
                n_mplr  = SQW'(r_umag[r_ax]);
                n_cnt   = CNTW'(UW);
                n_state = S_DOT;
            end
            S_DOT: begin
                n_acc   = w_mul_sum;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt - CNTW'(1);
                if (w_mul_last) begin
                    if (r_ax == AXW'(NAX-1)) begin
                        n_state = S_TSAT;
                    end else begin
                        n_ax    = r_ax + AXW'(1);
                        n_state = S_DOTLD;
                    end
                end
            end
            S_TSAT: begin
                n_t     = sat_cw($signed(r_acc) >>> FB);
                n_ax    = '0;
                n_state = S_PRJLD;
            end
            // projection offset t * u_i, rounded
            S_PRJLD: begin
                n_acc   = ACCW'(1) << (FB-1);
                n_mcand = r_uneg[r_ax] ? -w_tx : w_tx;
                n_mplr  = SQW'(r_umag[r_ax]);
                n_cnt   = CNTW'(UW);
                n_state = S_PRJ;
            end
            S_PRJ: begin
                n_acc   = w_mul_sum;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt - CNTW'(1);
                if (w_mul_last)
                    n_state = S_PADD;
            end
            S_PADD: begin
                n_proj[r_ax] = sat_cw(w_padd);
                if (r_ax == AXW'(NAX-1)) begin
                    n_state = S_DONE;
                end else begin
                    n_ax    = r_ax + AXW'(1);
                    n_state = S_PRJLD;
                end
            end
            // hand the result to the output register and track the extent
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_o_proj    = r_proj;
                    n_o_t       = r_t;
                    n_o_min     = w_nmin;
                    n_o_max     = w_nmax[CW-2:0];
                    n_o_degen   = r_degen;
                    n_run_min   = w_nmin;
                    n_run_max   = w_nmax;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // any register write invalidates the direction
        if (i_cfg_wr_en && i_cfg_idx <= CFG_END_Z)
            n_dir_ready = 1'b0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir_ready <= 1'b0;
            r_run_min   <= '0;
            r_run_max   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir_ready <= n_dir_ready;
            r_run_min   <= n_run_min;
            r_run_max   <= n_run_max;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_umag    <= n_umag;
        r_uneg    <= n_uneg;
        r_pt      <= n_pt;
        r_proj    <= n_proj;
        r_first   <= n_first;
        r_degen   <= n_degen;
        r_acc     <= n_acc;
        r_mcand   <= n_mcand;
        r_mplr    <= n_mplr;
        r_bit     <= n_bit;
        r_n       <= n_n;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_ax      <= n_ax;
        r_t       <= n_t;
        r_o_proj  <= n_o_proj;
        r_o_t     <= n_o_t;
        r_o_min   <= n_o_min;
        r_o_max   <= n_o_max;
        r_o_degen <= n_o_degen;
    end

    // Ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_o_max, r_o_min, r_o_t,
                         r_o_proj[2], r_o_proj[1], r_o_proj[0]};
    assign o_m_tuser  = r_o_degen;

endmodule

`default_nettype wire
